/* hdl/psdf_pkg.sv */
// Shared constants and types for the palette scanline darken filter.
package psdf_pkg;

  localparam int FRAME_WIDTH     = 256;
  localparam int FRAME_HEIGHT    = 240;
  localparam int PALETTE_ENTRIES = 512;

  localparam int PAL_AW   = $clog2(PALETTE_ENTRIES);
  localparam int IDX_W    = 9;
  localparam int COLOR_W  = 32;
  localparam int GAIN_W   = 9;
  localparam int COORD_W  = 9;
  localparam int COL_W    = 8;
  localparam int ROW_W    = 8;
  localparam int PROD_W   = GAIN_W + COLOR_W;
  localparam int NARROW_W = 16;

  localparam int SHIFT_WIDE   = 8;
  localparam int SHIFT_NARROW = 5;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_DOUBLE_SIZE   = 3'd0,
    REG_WIDE_COLOR    = 3'd1,
    REG_SCANLINE_GAIN = 3'd2,
    REG_GREEN_MASK    = 3'd3,
    REG_RED_BLUE_MASK = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_PALETTE_WRITE = 1'b0,
    CMD_PIXEL         = 1'b1
  } cmd_t;

  localparam logic [GAIN_W-1:0]  GAIN_RESET     = GAIN_W'(256);
  localparam logic [COLOR_W-1:0] GREEN_RESET    = 32'h0000_FF00;
  localparam logic [COLOR_W-1:0] RED_BLUE_RESET = 32'h00FF_00FF;

  // Cut a colour to 16 bits in narrow colour mode.
  function automatic logic [COLOR_W-1:0] fit_color(input logic [COLOR_W-1:0] c,
                                                   input logic wide);
    logic [COLOR_W-1:0] r;
    r = wide ? c : {{(COLOR_W-NARROW_W){1'b0}}, c[NARROW_W-1:0]};
    return r;
  endfunction

endpackage

/* hdl/psdf_item_if.sv */
// Input channel: palette writes and source pixels.
interface psdf_item_if
  import psdf_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [IDX_W-1:0]   palette_slot;
  logic [COLOR_W-1:0] palette_value;
  logic [IDX_W-1:0]   pixel_code;

  modport source (output valid, command, palette_slot, palette_value, pixel_code,
                  input ready);
  modport sink   (input valid, command, palette_slot, palette_value, pixel_code,
                  output ready);
endinterface

/* hdl/psdf_result_if.sv */
// Output channel: output pixel writes with coordinates.
interface psdf_result_if
  import psdf_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_row;
  logic [COLOR_W-1:0] out_color;
  logic               last_of_run;

  modport source (output valid, out_column, out_row, out_color, last_of_run,
                  input ready);
  modport sink   (input valid, out_column, out_row, out_color, last_of_run,
                  output ready);
endinterface

/* hdl/palette_scanline_darken_filter.sv */
// Palette scanline darken filter: palette memory, raster counters and CRT scanline output.
//
// Requests on the item channel are either palette writes or source pixels in raster order.
// A palette write updates the 512 x 32 palette memory and yields no result; a slot beyond
// the palette is dropped. A source pixel reads the palette (registered read), then the two
// colour-field products are formed by a 9 x 32 multiply stage, and the result stage emits
// one output write per cycle unless the output stalls: four writes per pixel in double-size
// mode (two normal on row 2*row, two darkened on row 2*row+1), one write in source-size mode
// (darkened on odd rows). Throughput, set by the single output register, is one pixel per
// cycle in source-size mode; a doubled pixel waits for the last write of the one before. A
// pixel passes the palette read, stage-2 and output registers before its first result
// appears. A pixel code beyond the palette reads colour zero. The palette needs no clearing
// pass: reading an entry never written returns whatever the memory holds. Registers sit on
// an APB port at byte address 4*i and may be changed only while no request is in flight.
module palette_scanline_darken_filter
  import psdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  psdf_item_if.sink         item,
  psdf_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------- registers
  logic               double_size;
  logic               wide_color;
  logic [GAIN_W-1:0]  scanline_gain;
  logic [COLOR_W-1:0] green_mask;
  logic [COLOR_W-1:0] red_blue_mask;
  logic               cfg_wr;
  logic [2:0]         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      double_size   <= 1'b0;
      wide_color    <= 1'b1;
      scanline_gain <= GAIN_RESET;
      green_mask    <= GREEN_RESET;
      red_blue_mask <= RED_BLUE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DOUBLE_SIZE:   double_size   <= pwdata[0];
        REG_WIDE_COLOR:    wide_color    <= pwdata[0];
        REG_SCANLINE_GAIN: scanline_gain <= pwdata[GAIN_W-1:0];
        REG_GREEN_MASK:    green_mask    <= pwdata;
        REG_RED_BLUE_MASK: red_blue_mask <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_DOUBLE_SIZE:   prdata = {{(APB_DW-1){1'b0}}, double_size};
      REG_WIDE_COLOR:    prdata = {{(APB_DW-1){1'b0}}, wide_color};
      REG_SCANLINE_GAIN: prdata = {{(APB_DW-GAIN_W){1'b0}}, scanline_gain};
      REG_GREEN_MASK:    prdata = green_mask;
      REG_RED_BLUE_MASK: prdata = red_blue_mask;
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline control
  logic s1_valid, s1_adv;
  logic s2_valid, s2_done;
  logic out_load;
  logic item_acc, pix_acc, pal_wr;

  assign item.ready = !s1_valid || s1_adv;
  assign item_acc   = item.valid && item.ready;
  assign pix_acc    = item_acc && (item.command == CMD_PIXEL);
  // Drop writes to slots beyond the palette.
  assign pal_wr     = item_acc && (item.command == CMD_PALETTE_WRITE) &&
                      ({1'b0, item.palette_slot} < (IDX_W+1)'(PALETTE_ENTRIES));

  // ---------------------------------------------------------------- raster counters
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pix_acc) begin
      if (column_count == COL_W'(FRAME_WIDTH - 1)) begin
        column_count <= '0;
        if (row_count == ROW_W'(FRAME_HEIGHT - 1)) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- palette memory
  // Each request either writes or reads, so one port access per cycle; a read issued
  // the cycle after a write to the same entry already sees the new colour.
  logic [COLOR_W-1:0] palette_store [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] pal_rd_data;

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      palette_store[item.palette_slot[PAL_AW-1:0]] <= item.palette_value;
    end
  end

  // Read data holds while stage 1 stalls: only a new pixel issues a read.
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pal_rd_data <= palette_store[item.pixel_code[PAL_AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- stage 1: palette read
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_in_range;

  assign s1_adv = s1_valid && (!s2_valid || s2_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_col      <= column_count;
      s1_row      <= row_count;
      s1_in_range <= {1'b0, item.pixel_code} < (IDX_W+1)'(PALETTE_ENTRIES);
    end
  end

  // ---------------------------------------------------------------- stage 2: field products
  logic [COLOR_W-1:0] s1_color;
  logic [COL_W-1:0]   s2_col;
  logic [ROW_W-1:0]   s2_row;
  logic [COLOR_W-1:0] s2_normal;
  logic [PROD_W-1:0]  s2_green_prod;
  logic [PROD_W-1:0]  s2_rb_prod;
  logic [1:0]         s2_idx;

  // Out-of-range codes read colour zero.
  assign s1_color = s1_in_range ? pal_rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_col        <= s1_col;
      s2_row        <= s1_row;
      s2_normal     <= fit_color(s1_color, wide_color);
      s2_green_prod <= PROD_W'(scanline_gain) * PROD_W'(s1_color & green_mask);
      s2_rb_prod    <= PROD_W'(scanline_gain) * PROD_W'(s1_color & red_blue_mask);
    end
  end

  // Darkened colour: shift each product, keep the low word, mask back into its field.
  logic [PROD_W-1:0]  green_sh;
  logic [PROD_W-1:0]  rb_sh;
  logic [COLOR_W-1:0] s2_dark;

  always_comb begin
    green_sh = wide_color ? (s2_green_prod >> SHIFT_WIDE) : (s2_green_prod >> SHIFT_NARROW);
    rb_sh    = wide_color ? (s2_rb_prod >> SHIFT_WIDE)    : (s2_rb_prod >> SHIFT_NARROW);
    s2_dark  = fit_color((green_sh[COLOR_W-1:0] & green_mask) |
                         (rb_sh[COLOR_W-1:0] & red_blue_mask), wide_color);
  end

  // ---------------------------------------------------------------- result sequencing
  // idx walks the four writes of a doubled pixel: bit 0 picks the odd column,
  // bit 1 the darkened row below.
  logic               s2_last;
  logic [COORD_W-1:0] nxt_column;
  logic [COORD_W-1:0] nxt_row;
  logic [COLOR_W-1:0] nxt_color;

  always_comb begin
    if (double_size) begin
      s2_last    = (s2_idx == 2'd3);
      nxt_column = {s2_col, s2_idx[0]};
      nxt_row    = {s2_row, s2_idx[1]};
      nxt_color  = s2_idx[1] ? s2_dark : s2_normal;
    end else begin
      s2_last    = 1'b1;
      nxt_column = {{(COORD_W-COL_W){1'b0}}, s2_col};
      nxt_row    = {{(COORD_W-ROW_W){1'b0}}, s2_row};
      nxt_color  = s2_row[0] ? s2_dark : s2_normal;
    end
  end

  assign out_load = s2_valid && (!result.valid || result.ready);
  assign s2_done  = out_load && s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_idx <= '0;
    end else if (s2_done) begin
      s2_idx <= '0;
    end else if (out_load) begin
      s2_idx <= s2_idx + 1'b1;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.out_column  <= nxt_column;
      result.out_row     <= nxt_row;
      result.out_color   <= nxt_color;
      result.last_of_run <= s2_last;
    end
  end

endmodule
